### hw/rtl/amsm_pkg.sv
// ----------------------------------------------------------------------------
// amsm_pkg
// Shared types, widths and exponential tables for the top-1 softmax block.
// ----------------------------------------------------------------------------
package amsm_pkg;

	localparam int LOGIT_W = 16;
	localparam int CLASS_W = 10;
	localparam int SCORE_W = 16;
	localparam int CNT_W   = 17;
	localparam int ACC_W   = 27;
	localparam int TERM_W  = 17;
	localparam int REM_W   = 28;

	localparam logic [ACC_W-1:0]   ACC_MAX   = '1;
	localparam logic [ACC_W-1:0]   ONE_Q16   = 27'd65536;
	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	typedef struct packed {
		logic signed [LOGIT_W-1:0] logit;
		logic                      last;
	} in_item_t;

	typedef struct packed {
		logic [CLASS_W-1:0] top_class;
		logic [SCORE_W-1:0] top_score;
		logic               truncated;
	} out_item_t;

	typedef struct packed {
		logic                      bank;
		logic [CNT_W-1:0]          count;
		logic signed [LOGIT_W-1:0] max;
		logic [CLASS_W-1:0]        best;
		logic                      overflow;
	} job_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	// round(65536 * e^-a), a = 0..15
	localparam logic [TERM_W-1:0] EXP_INT [16] = '{
		17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
		17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0
	};

	// round(65536 * e^(-h/16))
	localparam logic [TERM_W-1:0] EXP_HI [16] = '{
		17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947, 17'd45042,
		17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32953, 17'd30957, 17'd29081,
		17'd27319, 17'd25664
	};

	// round(65536 * e^(-l/256))
	localparam logic [TERM_W-1:0] EXP_LO [16] = '{
		17'd65536, 17'd65280, 17'd65026, 17'd64772, 17'd64520, 17'd64268, 17'd64018,
		17'd63768, 17'd63520, 17'd63272, 17'd63025, 17'd62780, 17'd62535, 17'd62291,
		17'd62048, 17'd61806
	};

endpackage

### hw/rtl/amsm_ram.sv
// ----------------------------------------------------------------------------
// amsm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module amsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/amsm_front.sv
// ----------------------------------------------------------------------------
// amsm_front
// Takes logits, writes them to the current store bank, tracks max and argmax,
// and queues a job descriptor when the vector closes.
// ----------------------------------------------------------------------------
module amsm_front #(
	parameter int MAX_CLASSES = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  amsm_pkg::in_item_t                   item,
	output logic                                 busy,
	output logic                                 ram_we,
	output logic [$clog2(MAX_CLASSES):0]         ram_waddr,
	output logic [amsm_pkg::LOGIT_W-1:0]         ram_wdata,
	output logic                                 push,
	output amsm_pkg::job_t                       job,
	input  amsm_pkg::release_t                   rel
);

	localparam int AW = $clog2(MAX_CLASSES);
	localparam int CW = $clog2(MAX_CLASSES + 1);

	logic [CW-1:0]                       cnt_q;
	logic signed [amsm_pkg::LOGIT_W-1:0] max_q;
	logic [AW-1:0]                       best_q;
	logic                                ovf_q;
	logic                                wbank_q;
	logic [1:0]                          bank_busy_q;

	logic                                accept;
	logic                                room;
	logic                                take_new;
	logic [CW-1:0]                       cnt_nxt;
	logic signed [amsm_pkg::LOGIT_W-1:0] max_nxt;
	logic [AW-1:0]                       best_nxt;
	logic                                ovf_nxt;

	assign busy     = bank_busy_q[wbank_q];
	assign accept   = start & ~busy;
	assign room     = (cnt_q != CW'(MAX_CLASSES));
	assign take_new = accept & room & ((cnt_q == '0) | ($signed(item.logit) > max_q));

	assign cnt_nxt  = (accept & room) ? CW'(cnt_q + 1'b1) : cnt_q;
	assign max_nxt  = take_new ? item.logit : max_q;
	assign best_nxt = take_new ? cnt_q[AW-1:0] : best_q;
	assign ovf_nxt  = ovf_q | (accept & ~room);

	assign ram_we    = accept & room;
	assign ram_waddr = {wbank_q, cnt_q[AW-1:0]};
	assign ram_wdata = item.logit;

	assign push         = accept & item.last;
	assign job.bank     = wbank_q;
	assign job.count    = amsm_pkg::CNT_W'(cnt_nxt);
	assign job.max      = max_nxt;
	assign job.best     = amsm_pkg::CLASS_W'(best_nxt);
	assign job.overflow = ovf_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			max_q       <= '0;
			best_q      <= '0;
			ovf_q       <= 1'b0;
			wbank_q     <= 1'b0;
			bank_busy_q <= '0;
		end else begin
			if (push) begin
				cnt_q   <= '0;
				max_q   <= '0;
				best_q  <= '0;
				ovf_q   <= 1'b0;
				wbank_q <= ~wbank_q;
			end else begin
				cnt_q  <= cnt_nxt;
				max_q  <= max_nxt;
				best_q <= best_nxt;
				ovf_q  <= ovf_nxt;
			end
			for (int b = 0; b < 2; b++) begin
				if (push && wbank_q == 1'(b)) begin
					bank_busy_q[b] <= 1'b1;
				end else if (rel.valid && rel.bank == 1'(b)) begin
					bank_busy_q[b] <= 1'b0;
				end
			end
		end
	end

endmodule

### hw/rtl/amsm_queue.sv
// ----------------------------------------------------------------------------
// amsm_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module amsm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  amsm_pkg::job_t push_job,
	input  logic           pop,
	output amsm_pkg::job_t head,
	output logic           valid,
	output logic           full
);

	amsm_pkg::job_t ent_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	assign head  = ent_q[rd_q];
	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### hw/rtl/amsm_div.sv
// ----------------------------------------------------------------------------
// amsm_div
// Radix-2 restoring divider for 2^32 / sum, saturated to 16 bits.
// ----------------------------------------------------------------------------
module amsm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [amsm_pkg::ACC_W-1:0]   den,
	output logic                         done,
	output logic [amsm_pkg::SCORE_W-1:0] quo
);

	typedef enum logic {
		IDLE,
		RUN
	} state_t;

	state_t                       state_q;
	logic [amsm_pkg::REM_W-1:0]   rem_q;
	logic [amsm_pkg::ACC_W-1:0]   den_q;
	logic [3:0]                   bit_q;
	logic [amsm_pkg::REM_W-1:0]   rem_sh;
	logic                         ge;

	assign rem_sh = {rem_q[amsm_pkg::REM_W-2:0], 1'b0};
	assign ge     = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			rem_q   <= '0;
			den_q   <= '0;
			bit_q   <= '0;
			done    <= 1'b0;
			quo     <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start) begin
						// quotient >= 2^16 exactly when den <= 2^16
						if (den <= amsm_pkg::ONE_Q16) begin
							quo  <= amsm_pkg::SCORE_MAX;
							done <= 1'b1;
						end else begin
							rem_q   <= amsm_pkg::REM_W'(amsm_pkg::ONE_Q16);
							den_q   <= den;
							bit_q   <= 4'd15;
							quo     <= '0;
							state_q <= RUN;
						end
					end
				end
				RUN: begin
					rem_q <= ge ? amsm_pkg::REM_W'(rem_sh - {1'b0, den_q}) : rem_sh;
					quo   <= {quo[amsm_pkg::SCORE_W-2:0], ge};
					bit_q <= bit_q - 4'd1;
					if (bit_q == 4'd0) begin
						done    <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/amsm_back.sv
// ----------------------------------------------------------------------------
// amsm_back
// Walks a stored vector through the exp pipeline, accumulates the sum,
// divides, and issues the result strobe.
// ----------------------------------------------------------------------------
module amsm_back #(
	parameter int MAX_CLASSES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  amsm_pkg::job_t                      q_head,
	output logic                                pop,
	output logic                                ram_re,
	output logic [$clog2(MAX_CLASSES):0]        ram_raddr,
	input  logic [amsm_pkg::LOGIT_W-1:0]        ram_rdata,
	output amsm_pkg::release_t                  rel,
	output logic                                div_start,
	output logic [amsm_pkg::ACC_W-1:0]          div_den,
	input  logic                                div_done,
	input  logic [amsm_pkg::SCORE_W-1:0]        div_quo,
	output logic                                done,
	output amsm_pkg::out_item_t                 result
);

	localparam int AW = $clog2(MAX_CLASSES);

	typedef enum logic [1:0] {
		IDLE,
		WALK,
		DRAIN,
		DIVIDE
	} state_t;

	state_t         state_q;
	amsm_pkg::job_t job_q;
	logic [AW-1:0]  idx_q;
	logic [AW-1:0]  last_idx;
	logic           last_rd;
	logic           pipe_busy;

	logic                          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [15:0]                   d_s2;
	logic [33:0]                   prod1_s3;
	logic [7:0]                    a_s3, a_s4;
	logic [amsm_pkg::TERM_W-1:0]   f_s4;
	logic [33:0]                   prod2_s5;
	logic                          far_s5;
	logic [amsm_pkg::ACC_W-1:0]    acc_q;

	logic [16:0]                   diff;
	logic [33:0]                   f_sum;
	logic [33:0]                   t_sum;
	logic [amsm_pkg::TERM_W-1:0]   term;
	logic [amsm_pkg::ACC_W:0]      acc_sum;

	assign last_idx  = AW'(job_q.count - 1'b1);
	assign ram_re    = (state_q == WALK);
	assign ram_raddr = {job_q.bank, idx_q};
	assign last_rd   = ram_re && (idx_q == last_idx);
	assign rel.valid = last_rd;
	assign rel.bank  = job_q.bank;
	assign pop       = (state_q == IDLE) && q_valid;
	assign pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
	assign div_start = (state_q == DRAIN) && !pipe_busy;
	assign div_den   = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			job_q   <= '0;
			idx_q   <= '0;
			done    <= 1'b0;
			result  <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				IDLE: begin
					if (q_valid) begin
						job_q   <= q_head;
						idx_q   <= '0;
						state_q <= WALK;
					end
				end
				WALK: begin
					idx_q <= idx_q + 1'b1;
					if (last_rd) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (!pipe_busy) begin
						state_q <= DIVIDE;
					end
				end
				DIVIDE: begin
					if (div_done) begin
						result.top_class <= job_q.best;
						result.top_score <= div_quo;
						result.truncated <= job_q.overflow;
						done             <= 1'b1;
						state_q          <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// exp(-(max - v)) pipeline
	assign diff  = {job_q.max[15], job_q.max} - {ram_rdata[15], ram_rdata};
	assign f_sum = prod1_s3 + 34'd32768;
	assign t_sum = prod2_s5 + 34'd32768;
	assign term  = far_s5 ? '0 : t_sum[32:16];
	assign acc_sum = {1'b0, acc_q} + (amsm_pkg::ACC_W + 1)'(term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= ram_re;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		d_s2     <= diff[15:0];
		prod1_s3 <= 34'(amsm_pkg::EXP_HI[d_s2[7:4]]) * 34'(amsm_pkg::EXP_LO[d_s2[3:0]]);
		a_s3     <= d_s2[15:8];
		f_s4     <= f_sum[32:16];
		a_s4     <= a_s3;
		prod2_s5 <= 34'(amsm_pkg::EXP_INT[a_s4[3:0]]) * 34'(f_s4);
		far_s5   <= (a_s4[7:4] != 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (pop) begin
			acc_q <= '0;
		end else if (v_s5) begin
			acc_q <= (acc_sum > {1'b0, amsm_pkg::ACC_MAX}) ? amsm_pkg::ACC_MAX
			                                               : acc_sum[amsm_pkg::ACC_W-1:0];
		end
	end

endmodule

### hw/rtl/argmax_softmax_top1_top.sv
// ----------------------------------------------------------------------------
// argmax_softmax_top1_top
// Top-1 classifier: argmax of a logit vector plus its softmax confidence.
// ----------------------------------------------------------------------------
// Logits are taken one per cycle (start high, busy low); last closes the
// vector. The store has two banks: while one closed vector is summed, the
// next one loads into the other bank, and busy rises only when both banks are
// held. Closing a vector of N stored logits takes one read per element on
// the store's single read port, through a five-stage exp pipeline, then a
// radix-2 restoring divider. The result appears on result for exactly one
// cycle with done high; there is no way to hold it, so sample it then.
// The store needs no clearing after reset; only entries written in the
// current vector are read.
// ----------------------------------------------------------------------------
module argmax_softmax_top1_top #(
	parameter int MAX_CLASSES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  amsm_pkg::in_item_t  item,
	output logic                busy,
	output logic                done,
	output amsm_pkg::out_item_t result
);

	localparam int AW        = $clog2(MAX_CLASSES);
	localparam int RAM_DEPTH = 2 ** (AW + 1);

	logic                                ram_we;
	logic [AW:0]                         ram_waddr;
	logic [amsm_pkg::LOGIT_W-1:0]        ram_wdata;
	logic                                ram_re;
	logic [AW:0]                         ram_raddr;
	logic [amsm_pkg::LOGIT_W-1:0]        ram_rdata;

	logic                                push;
	amsm_pkg::job_t                      push_job;
	logic                                pop;
	amsm_pkg::job_t                      q_head;
	logic                                q_valid;
	logic                                q_full;
	amsm_pkg::release_t                  rel;

	logic                                div_start;
	logic [amsm_pkg::ACC_W-1:0]          div_den;
	logic                                div_done;
	logic [amsm_pkg::SCORE_W-1:0]        div_quo;

	amsm_ram #(
		.WIDTH(amsm_pkg::LOGIT_W),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	amsm_front #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.busy     (busy),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.push     (push),
		.job      (push_job),
		.rel      (rel)
	);

	amsm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (q_head),
		.valid   (q_valid),
		.full    (q_full)
	);

	amsm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	amsm_back #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.pop      (pop),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.rel      (rel),
		.div_start(div_start),
		.div_den  (div_den),
		.div_done (div_done),
		.div_quo  (div_quo),
		.done     (done),
		.result   (result)
	);

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into full queue");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_score_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.top_score != '0))
		else $error("zero confidence on result");

	a_release_walking: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |-> ram_re)
		else $error("bank released outside a store walk");

endmodule

### tb/argmax_softmax_top1_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argmax_softmax_top1_checker
// Watches the logit and result channels of the top-1 softmax block, predicts
// the best class, the softmax confidence and the overflow flag of every
// closed vector, and compares each result with the oldest expected one.
// ----------------------------------------------------------------------------
module argmax_softmax_top1_checker #(
	parameter int MAX_CLASSES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  amsm_pkg::in_item_t  item,
	input  logic                done,
	input  amsm_pkg::out_item_t result,
	output int                  errors,
	output int                  pending
);

	localparam longint unsigned SUM_CAP   = (64'd1 << amsm_pkg::ACC_W) - 1;
	localparam longint unsigned SCORE_TOP = 64'd65535;

	// e^-a, e^(-h/16), e^(-l/256) in Q16
	localparam int unsigned E_WHOLE [16] = '{
		65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1, 0, 0, 0, 0
	};
	localparam int unsigned E_SIXTEENTH [16] = '{
		65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
		39750, 37341, 35079, 32953, 30957, 29081, 27319, 25664
	};
	localparam int unsigned E_FINE [16] = '{
		65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
		63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806
	};

	int                  logit_mem [MAX_CLASSES];
	int                  vec_count;
	int                  vec_peak;
	int                  vec_best;
	bit                  vec_trunc;
	amsm_pkg::out_item_t score_q [$];

	function automatic longint unsigned exp_q16(input int unsigned d);
		int unsigned       whole;
		longint unsigned   frac;
		whole = d >> 8;
		if (whole >= 16)
			return 0;
		frac = (longint'(E_SIXTEENTH[(d >> 4) & 15]) * E_FINE[d & 15] + 32768) >> 16;
		return (longint'(E_WHOLE[whole]) * frac + 32768) >> 16;
	endfunction

	function automatic amsm_pkg::out_item_t close_vector();
		longint unsigned     sum;
		longint unsigned     score;
		amsm_pkg::out_item_t r;
		sum = 0;
		for (int i = 0; i < vec_count; i++) begin
			sum += exp_q16(int'(vec_peak - logit_mem[i]));
			if (sum > SUM_CAP)
				sum = SUM_CAP;
		end
		score = (sum == 0) ? SCORE_TOP : (64'd1 << 32) / sum;
		if (score > SCORE_TOP)
			score = SCORE_TOP;
		r.top_class = vec_best[amsm_pkg::CLASS_W-1:0];
		r.top_score = score[amsm_pkg::SCORE_W-1:0];
		r.truncated = vec_trunc;
		return r;
	endfunction

	task automatic take_logit(input int x, input bit lst);
		if (vec_count < MAX_CLASSES) begin
			logit_mem[vec_count] = x;
			if (vec_count == 0 || x > vec_peak) begin
				vec_peak = x;
				vec_best = vec_count;
			end
			vec_count++;
		end else begin
			vec_trunc = 1'b1;
		end
		if (lst) begin
			score_q = {score_q, close_vector()};
			vec_count = 0;
			vec_peak  = 0;
			vec_best  = 0;
			vec_trunc = 1'b0;
		end
	endtask

	task automatic compare_result();
		amsm_pkg::out_item_t want;
		want = score_q.pop_front();
		if (result.top_class !== want.top_class) begin
			$error("top_class: expected %0d, got %0d", want.top_class, result.top_class);
			errors++;
		end
		if (result.top_score !== want.top_score) begin
			$error("top_score: expected %0d, got %0d", want.top_score, result.top_score);
			errors++;
		end
		if (result.truncated !== want.truncated) begin
			$error("truncated: expected %0d, got %0d", want.truncated, result.truncated);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_count = 0;
			vec_peak  = 0;
			vec_best  = 0;
			vec_trunc = 1'b0;
			score_q.delete();
			errors    = 0;
			pending  <= 0;
		end else begin
			if (start && !busy)
				take_logit($signed(item.logit), item.last);
			if (done === 1'b1) begin
				if (score_q.size() == 0) begin
					$error("unexpected result: top_class %0d, top_score %0d",
						result.top_class, result.top_score);
					errors++;
				end else begin
					compare_result();
				end
			end
			pending <= score_q.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for argmax_softmax_top1_top.
// Sends directed logit vectors for the corner cases, then random vectors of
// mixed length and spread, one of them past the class limit, with random
// idle gaps; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAX_CLASSES  = 1024;
	localparam int ITEM_TARGET  = 1950;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 64;

	typedef enum int {VK_WIDE, VK_NARROW, VK_TIES} vec_kind_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	amsm_pkg::in_item_t  item;
	logic                busy;
	logic                done;
	amsm_pkg::out_item_t result;
	int                  errors;
	int                  pending;
	int                  cycles = 0;
	int                  items_sent = 0;
	bit                  steady = 1'b0;

	always #5 clk = ~clk;

	argmax_softmax_top1_top #(
		.MAX_CLASSES(MAX_CLASSES)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	argmax_softmax_top1_checker #(
		.MAX_CLASSES(MAX_CLASSES)
	) i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			n = 0;
		else if (r < 95)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(8, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(input int v, input bit lst);
		amsm_pkg::in_item_t it;
		it.logit = v[amsm_pkg::LOGIT_W-1:0];
		it.last  = lst;
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		idle_gap();
	endtask

	function automatic int clamp16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int pick_logit(input vec_kind_t k, input int base);
		case (k)
			VK_NARROW: return clamp16(base + int'($urandom_range(0, 3071)) - 2048);
			VK_TIES:   return clamp16(base - 256 * int'($urandom_range(0, 2)));
			default:   return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	task automatic send_vector(input int n, input vec_kind_t k);
		int base;
		base = int'($urandom_range(0, 65535)) - 32768;
		for (int i = 0; i < n; i++)
			send_item(pick_logit(k, base), i == n - 1);
	endtask

	task automatic random_vector();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 70)
			n = $urandom_range(1, 8);
		else if (r < 95)
			n = $urandom_range(9, 40);
		else
			n = $urandom_range(41, 160);
		steady = ($urandom_range(0, 3) == 0);
		send_vector(n, vec_kind_t'($urandom_range(0, 2)));
	endtask

	// one element past the limit; its large logit must not win
	task automatic send_overflow_vector();
		int peak;
		int v;
		peak = $urandom_range(MAX_CLASSES / 2, MAX_CLASSES - 1);
		steady = 1'b0;
		for (int i = 0; i <= MAX_CLASSES; i++) begin
			if (i == peak)
				v = 4000;
			else if (i >= MAX_CLASSES)
				v = 32767;
			else
				v = int'($urandom_range(0, 4095)) - 2048;
			send_item(v, i == MAX_CLASSES);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-element vectors saturate the score
		send_item(32767, 1'b1);
		send_item(-32768, 1'b1);
		// full-range spread, far term is zero
		send_item(-32768, 1'b0);
		send_item(32767, 1'b1);
		// tie keeps the first index
		send_item(100, 1'b0);
		send_item(100, 1'b1);
		// exactly 16.0 below the max
		send_item(0, 1'b0);
		send_item(-4096, 1'b1);
		send_item(0, 1'b0);
		send_item(-4095, 1'b0);
		send_item(-2816, 1'b1);
		// all negative, max not first
		send_item(-300, 1'b0);
		send_item(-200, 1'b0);
		send_item(-200, 1'b0);
		send_item(-201, 1'b1);
		send_item(21845, 1'b0);
		send_item(-21846, 1'b0);
		send_item(21845, 1'b1);
		send_item(-1, 1'b0);
		send_item(0, 1'b0);
		send_item(1, 1'b1);

		while (items_sent < ITEM_TARGET / 4)
			random_vector();
		send_overflow_vector();
		while (items_sent < ITEM_TARGET)
			random_vector();

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
